>>> rtl/dtn_pkg.sv
// ----------------------------------------------------------------------------
// dtn_pkg
// Shared types and constants for the date and time normalizer: item
// payloads, divider stage codes and the controller to datapath bundles.
// ----------------------------------------------------------------------------
package dtn_pkg;

    // radix constants
    localparam logic [9:0]  MILLIS_PER_SEC  = 10'd1000;
    localparam logic [9:0]  SEC_PER_MIN     = 10'd60;
    localparam logic [9:0]  MIN_PER_HOUR    = 10'd60;
    localparam logic [9:0]  HOUR_PER_DAY    = 10'd24;
    localparam logic [8:0]  DAYS_LEAP       = 9'd366;
    localparam logic [8:0]  DAYS_COMMON     = 9'd365;
    localparam logic [11:0] YEARS_PER_CYCLE = 12'd400;
    localparam logic [11:0] YEAR_MOD_LAST   = 12'd399;
    localparam logic [13:0] YEAR_LIMIT      = 14'd4000;

    // reciprocals and shifts, exact for any 32-bit unsigned dividend
    localparam logic [31:0] RECIP_MILLIS    = 32'd274877907;
    localparam logic [5:0]  SHIFT_MILLIS    = 6'd38;
    localparam logic [31:0] RECIP_SIXTY     = 32'h88888889;
    localparam logic [5:0]  SHIFT_SIXTY     = 6'd37;
    localparam logic [31:0] RECIP_DAY       = 32'hAAAAAAAB;
    localparam logic [5:0]  SHIFT_DAY       = 6'd36;

    // input item
    typedef struct packed {
        logic        [11:0] in_year;
        logic signed [16:0] in_day;
        logic signed [16:0] in_hour;
        logic signed [16:0] in_minute;
        logic signed [20:0] in_second;
        logic signed [31:0] in_millis;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [12:0] out_year;
        logic        [8:0]  out_day;
        logic        [4:0]  out_hour;
        logic        [5:0]  out_minute;
        logic        [5:0]  out_second;
        logic        [9:0]  out_millis;
        logic               year_clamped;
    } t_out_item;

    // carry stage handled by the shared divider
    typedef enum logic [1:0] {
        STG_MILLIS = 2'd0,
        STG_SECOND = 2'd1,
        STG_MINUTE = 2'd2,
        STG_HOUR   = 2'd3
    } t_stage;

    // controller commands to the datapath
    typedef struct packed {
        logic   load;
        logic   ymod_step;
        logic   div_start;
        logic   div_step;
        logic   div_rem;
        logic   div_finish;
        logic   year_step;
        logic   out_load;
        t_stage stage;
    } t_dtn_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic ymod_big;
        logic year_busy;
    } t_dtn_sts;

endpackage

>>> rtl/dtn_if.sv
// ----------------------------------------------------------------------------
// dtn_if
// Valid/ready channels for the date and time normalizer: one for input
// tuples and one for normalized results.
// ----------------------------------------------------------------------------
interface dtn_in_if;
    logic               valid;
    logic               ready;
    logic        [11:0] in_year;
    logic signed [16:0] in_day;
    logic signed [16:0] in_hour;
    logic signed [16:0] in_minute;
    logic signed [20:0] in_second;
    logic signed [31:0] in_millis;

    modport source (
        output valid, in_year, in_day, in_hour, in_minute, in_second, in_millis,
        input  ready
    );
    modport sink (
        input  valid, in_year, in_day, in_hour, in_minute, in_second, in_millis,
        output ready
    );
endinterface

interface dtn_out_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] out_year;
    logic        [8:0]  out_day;
    logic        [4:0]  out_hour;
    logic        [5:0]  out_minute;
    logic        [5:0]  out_second;
    logic        [9:0]  out_millis;
    logic               year_clamped;

    modport source (
        output valid, out_year, out_day, out_hour, out_minute, out_second,
               out_millis, year_clamped,
        input  ready
    );
    modport sink (
        input  valid, out_year, out_day, out_hour, out_minute, out_second,
               out_millis, year_clamped,
        output ready
    );
endinterface

>>> rtl/dtn_datapath.sv
// ----------------------------------------------------------------------------
// dtn_datapath
// Working registers of one tuple, a shared reciprocal floored divider for
// the unit carries, the year walk with a tracked year mod 400, and the
// result register with the year overflow clamp.
// ----------------------------------------------------------------------------
module dtn_datapath
    import dtn_pkg::*;
(
    input  logic      i_clk,
    input  t_dtn_cmd  i_cmd,
    input  t_in_item  i_item,
    output t_dtn_sts  o_sts,
    output t_out_item o_result
);

    // leap rule on year mod 400
    function automatic logic is_leap(input logic [8:0] m);
        logic century;
        begin
            century = (m == 9'd100) || (m == 9'd200) || (m == 9'd300);
            return (m[1:0] == 2'b00) && !century;
        end
    endfunction

    // working fields
    logic signed [13:0] r_year;
    logic        [11:0] r_ymod;
    logic signed [17:0] r_day;
    logic signed [17:0] r_hour;
    logic signed [17:0] r_minute;
    logic signed [22:0] r_second;
    logic signed [31:0] r_millis;

    // divider state
    logic [31:0] r_dv_mag;
    logic [31:0] r_dv_quo;
    logic [9:0]  r_dv_rem;
    logic        r_dv_neg;

    // result register
    t_out_item r_result;

    // divider operand, divisor and reciprocal by stage
    logic signed [31:0] dv_a;
    logic        [9:0]  dv_b;
    logic        [31:0] dv_m;
    logic        [5:0]  dv_sh;
    logic        [31:0] dv_u;
    logic        [31:0] dv_mag;

    always_comb begin
        unique case (i_cmd.stage)
            STG_MILLIS: begin
                dv_a  = r_millis;
                dv_b  = MILLIS_PER_SEC;
                dv_m  = RECIP_MILLIS;
                dv_sh = SHIFT_MILLIS;
            end
            STG_SECOND: begin
                dv_a  = 32'(r_second);
                dv_b  = SEC_PER_MIN;
                dv_m  = RECIP_SIXTY;
                dv_sh = SHIFT_SIXTY;
            end
            STG_MINUTE: begin
                dv_a  = 32'(r_minute);
                dv_b  = MIN_PER_HOUR;
                dv_m  = RECIP_SIXTY;
                dv_sh = SHIFT_SIXTY;
            end
            STG_HOUR: begin
                dv_a  = 32'(r_hour);
                dv_b  = HOUR_PER_DAY;
                dv_m  = RECIP_DAY;
                dv_sh = SHIFT_DAY;
            end
            default: begin
                dv_a  = r_millis;
                dv_b  = MILLIS_PER_SEC;
                dv_m  = RECIP_MILLIS;
                dv_sh = SHIFT_MILLIS;
            end
        endcase
    end

    assign dv_u   = dv_a;
    assign dv_mag = dv_u[31] ? (~dv_u + 32'd1) : dv_u;

    // quotient of the magnitude by reciprocal, then the remainder
    logic [63:0] dv_prod;
    logic [63:0] dv_prod_sh;
    logic [31:0] dv_qd;
    logic [31:0] dv_rem_full;

    assign dv_prod     = {32'd0, r_dv_mag} * {32'd0, dv_m};
    assign dv_prod_sh  = dv_prod >> dv_sh;
    assign dv_qd       = r_dv_quo * {22'd0, dv_b};
    assign dv_rem_full = r_dv_mag - dv_qd;

    // floor correction for negative dividends
    logic        dv_rnz;
    logic [31:0] dv_q_fix;
    logic [9:0]  dv_r_fix;

    assign dv_rnz   = r_dv_rem != 10'd0;
    assign dv_q_fix = !r_dv_neg ? r_dv_quo : (dv_rnz ? ~r_dv_quo : (~r_dv_quo + 32'd1));
    assign dv_r_fix = (r_dv_neg && dv_rnz) ? (dv_b - r_dv_rem) : r_dv_rem;

    // year walk terms
    logic        [11:0] ymod_inc;
    logic        [11:0] ymod_dec;
    logic        [8:0]  len_cur;
    logic        [8:0]  len_prev;
    logic               day_ge;
    logic               day_neg;

    assign ymod_inc = (r_ymod == YEAR_MOD_LAST) ? 12'd0 : (r_ymod + 12'd1);
    assign ymod_dec = (r_ymod == 12'd0) ? YEAR_MOD_LAST : (r_ymod - 12'd1);
    assign len_cur  = is_leap(r_ymod[8:0]) ? DAYS_LEAP : DAYS_COMMON;
    assign len_prev = is_leap(ymod_dec[8:0]) ? DAYS_LEAP : DAYS_COMMON;
    assign day_ge   = r_day >= signed'(18'(len_cur));
    assign day_neg  = r_day[17];

    // clamp check
    logic clamp;
    assign clamp = r_year >= signed'(YEAR_LIMIT);

    // working field updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year   <= signed'({2'b00, i_item.in_year});
            r_ymod   <= i_item.in_year;
            r_day    <= 18'(i_item.in_day);
            r_hour   <= 18'(i_item.in_hour);
            r_minute <= 18'(i_item.in_minute);
            r_second <= 23'(i_item.in_second);
            r_millis <= i_item.in_millis;
        end else if (i_cmd.ymod_step) begin
            r_ymod <= r_ymod - YEARS_PER_CYCLE;
        end else if (i_cmd.div_finish) begin
            case (i_cmd.stage)
                STG_MILLIS: begin
                    r_millis <= signed'(32'(dv_r_fix));
                    r_second <= r_second + signed'(dv_q_fix[22:0]);
                end
                STG_SECOND: begin
                    r_second <= signed'(23'(dv_r_fix));
                    r_minute <= r_minute + signed'(dv_q_fix[17:0]);
                end
                STG_MINUTE: begin
                    r_minute <= signed'(18'(dv_r_fix));
                    r_hour   <= r_hour + signed'(dv_q_fix[17:0]);
                end
                default: begin
                    r_hour <= signed'(18'(dv_r_fix));
                    r_day  <= r_day + signed'(dv_q_fix[17:0]);
                end
            endcase
        end else if (i_cmd.year_step) begin
            if (day_ge) begin
                r_day  <= r_day - signed'(18'(len_cur));
                r_year <= r_year + 14'sd1;
                r_ymod <= ymod_inc;
            end else if (day_neg) begin
                r_day  <= r_day + signed'(18'(len_prev));
                r_year <= r_year - 14'sd1;
                r_ymod <= ymod_dec;
            end
        end
    end

    // shared divider: magnitude, quotient, remainder on successive cycles
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dv_mag <= dv_mag;
            r_dv_neg <= dv_u[31];
        end else if (i_cmd.div_step) begin
            r_dv_quo <= dv_prod_sh[31:0];
        end else if (i_cmd.div_rem) begin
            r_dv_rem <= dv_rem_full[9:0];
        end
    end

    // result register with overflow clamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (clamp) begin
                r_result.out_year     <= 13'sd0;
                r_result.out_day      <= 9'd1;
                r_result.out_hour     <= 5'd0;
                r_result.out_minute   <= 6'd0;
                r_result.out_second   <= 6'd0;
                r_result.out_millis   <= 10'd0;
                r_result.year_clamped <= 1'b1;
            end else begin
                r_result.out_year     <= r_year[12:0];
                r_result.out_day      <= r_day[8:0];
                r_result.out_hour     <= r_hour[4:0];
                r_result.out_minute   <= r_minute[5:0];
                r_result.out_second   <= r_second[5:0];
                r_result.out_millis   <= r_millis[9:0];
                r_result.year_clamped <= 1'b0;
            end
        end
    end

    assign o_sts.ymod_big  = r_ymod >= YEARS_PER_CYCLE;
    assign o_sts.year_busy = day_ge || day_neg;
    assign o_result        = r_result;

endmodule

>>> rtl/dtn_ctrl.sv
// ----------------------------------------------------------------------------
// dtn_ctrl
// Sequencer for the normalizer: takes a tuple, reduces the year mod 400,
// runs the four carry divisions, walks whole years and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module dtn_ctrl
    import dtn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dtn_sts i_sts,
    output t_dtn_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b00000001,
        S_YMOD    = 8'b00000010,
        S_DIV_LD  = 8'b00000100,
        S_DIV     = 8'b00001000,
        S_DIV_REM = 8'b00010000,
        S_DIV_WB  = 8'b00100000,
        S_YEAR    = 8'b01000000,
        S_OUT     = 8'b10000000
    } t_state;

    t_state          r_state, n_state;
    t_stage          r_stage, n_stage;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_stage     = r_stage;
        o_cmd       = '0;
        o_cmd.stage = r_stage;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_YMOD;
                end
            end
            S_YMOD: begin
                if (i_sts.ymod_big) begin
                    o_cmd.ymod_step = 1'b1;
                end else begin
                    n_stage = STG_MILLIS;
                    n_state = S_DIV_LD;
                end
            end
            S_DIV_LD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_DIV_REM;
            end
            S_DIV_REM: begin
                o_cmd.div_rem = 1'b1;
                n_state       = S_DIV_WB;
            end
            S_DIV_WB: begin
                o_cmd.div_finish = 1'b1;
                case (r_stage)
                    STG_MILLIS: begin
                        n_stage = STG_SECOND;
                        n_state = S_DIV_LD;
                    end
                    STG_SECOND: begin
                        n_stage = STG_MINUTE;
                        n_state = S_DIV_LD;
                    end
                    STG_MINUTE: begin
                        n_stage = STG_HOUR;
                        n_state = S_DIV_LD;
                    end
                    default: begin
                        n_state = S_YEAR;
                    end
                endcase
            end
            S_YEAR: begin
                if (i_sts.year_busy) begin
                    o_cmd.year_step = 1'b1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= STG_MILLIS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/date_time_normalizer.sv
// ----------------------------------------------------------------------------
// date_time_normalizer
// Normalizes a signed time tuple into canonical year, day of year, hour,
// minute, second and millisecond, clamping years of 4000 and above.
// ----------------------------------------------------------------------------
// sequence: after the input transfer the year is reduced mod 400 in steps,
//   the four carries pass through the reciprocal divider, whole years are
//   walked one at a time and the result is loaded into the output register
// throughput: one tuple at a time; the next one is taken the cycle after the
//   result is loaded, while that result waits in the output register
// reset: synchronous active low, sequencer to idle, output register emptied
module date_time_normalizer
    import dtn_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    dtn_in_if.sink     i_in,
    dtn_out_if.source  o_out
);

    t_dtn_cmd  cmd;
    t_dtn_sts  sts;
    t_in_item  in_item;
    t_out_item result;
    logic      in_ready;
    logic      out_valid;

    // pack input transfer payload
    assign in_item.in_year   = i_in.in_year;
    assign in_item.in_day    = i_in.in_day;
    assign in_item.in_hour   = i_in.in_hour;
    assign in_item.in_minute = i_in.in_minute;
    assign in_item.in_second = i_in.in_second;
    assign in_item.in_millis = i_in.in_millis;

    dtn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dtn_datapath u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_item   (in_item),
        .o_sts    (sts),
        .o_result (result)
    );

    // channel handshakes and result payload
    assign i_in.ready         = in_ready;
    assign o_out.valid        = out_valid;
    assign o_out.out_year     = result.out_year;
    assign o_out.out_day      = result.out_day;
    assign o_out.out_hour     = result.out_hour;
    assign o_out.out_minute   = result.out_minute;
    assign o_out.out_second   = result.out_second;
    assign o_out.out_millis   = result.out_millis;
    assign o_out.year_clamped = result.year_clamped;

endmodule
